// ----- rtl/csim_pkg.sv -----
`default_nettype none
package csim_pkg;

  localparam int unsigned DotW       = 44;
  localparam int unsigned NormW      = 43;
  localparam int unsigned SimW       = 16;
  localparam int unsigned MaxLenDef  = 4096;
  localparam int unsigned ElemWDef   = 16;
  localparam int unsigned QDepth     = 2;
  localparam int unsigned FracShift  = 20;
  localparam int unsigned DivShift   = 35;
  localparam int unsigned SqrtInW    = 64;
  localparam int unsigned RootW      = SqrtInW / 2;
  localparam int unsigned RemW       = RootW + 2;
  localparam int unsigned ProdW      = 2 * RootW;
  localparam int unsigned NumW       = DotW + DivShift;
  localparam int unsigned QW         = 21;
  localparam int unsigned StepW      = 7;

  localparam logic [NormW-1:0] NORM_MAX = '1;
  localparam logic [QW-1:0]    Q_CAP    = QW'(1) << 20;
  localparam logic [SimW-1:0]  SIM_ONE  = SimW'(16384);

  typedef struct packed {
    logic signed [DotW-1:0] dot;
    logic [NormW-1:0]       norm_a;
    logic [NormW-1:0]       norm_b;
    logic                   ovf;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQRT_A,
    B_SQRT_B,
    B_MUL,
    B_DIV,
    B_DONE
  } back_state_e;

endpackage
`default_nettype wire

// ----- rtl/csim_front.sv -----
`default_nettype none
module csim_front #(
  parameter int unsigned MaxLen = csim_pkg::MaxLenDef,
  parameter int unsigned ElemW  = csim_pkg::ElemWDef
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      valid_i,
  output logic                     ready_o,
  input  wire  signed [ElemW-1:0]  a_i,
  input  wire  signed [ElemW-1:0]  b_i,
  input  wire                      last_i,
  output logic                     push_o,
  output csim_pkg::job_t           job_o,
  input  wire                      full_i
);

  localparam int unsigned CntW = $clog2(MaxLen + 1);
  localparam int unsigned PW   = 2 * ElemW;
  localparam int unsigned SumW = ((PW > csim_pkg::DotW) ? PW : csim_pkg::DotW) + 1;
  localparam int unsigned DotW = csim_pkg::DotW;
  localparam int unsigned NormW = csim_pkg::NormW;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept, in_range;

  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_last_q, s1_en_q;
  logic signed [PW-1:0] pab_q;
  logic [PW-1:0]        paa_q, pbb_q;
  logic                 adv;

  logic signed [DotW-1:0] dot_q, dot_n;
  logic [NormW-1:0]       na_q, na_n, nb_q, nb_n;
  logic                   ovf_q, ovf_n;

  logic signed [SumW-1:0] dsum, dmax, dmin;
  logic [SumW-1:0]        asum, bsum, nmax;
  logic                   dsat, asat, bsat;
  logic signed [DotW-1:0] dclip;
  logic [NormW-1:0]       aclip, bclip;

  assign accept   = valid_i && ready_o;
  assign in_range = cnt_q < CntW'(MaxLen);
  assign adv      = s1_valid_q && !(s1_last_q && full_i);
  assign ready_o  = !s1_valid_q || adv;

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (last_i) begin
        cnt_d = '0;
      end else if (in_range) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
    s1_valid_d = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_q);
  end

  // saturating accumulate
  always_comb begin
    dmax  = {{(SumW-DotW+1){1'b0}}, {(DotW-1){1'b1}}};
    dmin  = {{(SumW-DotW+1){1'b1}}, {(DotW-1){1'b0}}};
    nmax  = {{(SumW-NormW){1'b0}}, csim_pkg::NORM_MAX};
    dsum  = {{(SumW-DotW){dot_q[DotW-1]}}, dot_q} + {{(SumW-PW){pab_q[PW-1]}}, pab_q};
    asum  = {{(SumW-NormW){1'b0}}, na_q} + {{(SumW-PW){1'b0}}, paa_q};
    bsum  = {{(SumW-NormW){1'b0}}, nb_q} + {{(SumW-PW){1'b0}}, pbb_q};
    dsat  = (dsum > dmax) || (dsum < dmin);
    asat  = asum > nmax;
    bsat  = bsum > nmax;
    if (dsum > dmax) begin
      dclip = dmax[DotW-1:0];
    end else if (dsum < dmin) begin
      dclip = dmin[DotW-1:0];
    end else begin
      dclip = dsum[DotW-1:0];
    end
    aclip = asat ? csim_pkg::NORM_MAX : asum[NormW-1:0];
    bclip = bsat ? csim_pkg::NORM_MAX : bsum[NormW-1:0];
    dot_n = s1_en_q ? dclip : dot_q;
    na_n  = s1_en_q ? aclip : na_q;
    nb_n  = s1_en_q ? bclip : nb_q;
    ovf_n = ovf_q || !s1_en_q || (s1_en_q && (dsat || asat || bsat));
  end

  assign push_o       = adv && s1_last_q;
  assign job_o.dot    = dot_n;
  assign job_o.norm_a = na_n;
  assign job_o.norm_b = nb_n;
  assign job_o.ovf    = ovf_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_en_q    <= 1'b0;
      dot_q      <= '0;
      na_q       <= '0;
      nb_q       <= '0;
      ovf_q      <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        s1_last_q <= last_i;
        s1_en_q   <= in_range;
      end
      if (adv) begin
        if (s1_last_q) begin
          dot_q <= '0;
          na_q  <= '0;
          nb_q  <= '0;
          ovf_q <= 1'b0;
        end else begin
          dot_q <= dot_n;
          na_q  <= na_n;
          nb_q  <= nb_n;
          ovf_q <= ovf_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pab_q <= a_i * b_i;
      paa_q <= a_i * a_i;
      pbb_q <= b_i * b_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxLen))
    else $error("element count beyond maximum length");

  a_push_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (dot_q == '0) && (na_q == '0) && (nb_q == '0) && !ovf_q)
    else $error("accumulators not cleared after last element");

endmodule
`default_nettype wire

// ----- rtl/csim_queue.sv -----
`default_nettype none
module csim_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  csim_pkg::job_t  job_i,
  output logic            full_o,
  input  wire             pop_i,
  output csim_pkg::job_t  job_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = $clog2(csim_pkg::QDepth);
  localparam int unsigned CntW = $clog2(csim_pkg::QDepth + 1);

  csim_pkg::job_t mem_q [csim_pkg::QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(csim_pkg::QDepth);
  assign empty_o = cnt_q == '0;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(csim_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(csim_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && empty_o))
    else $error("queue overrun or underrun");

endmodule
`default_nettype wire

// ----- rtl/csim_back.sv -----
`default_nettype none
module csim_back (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         empty_i,
  input  csim_pkg::job_t              job_i,
  output logic                        pop_o,
  output logic                        valid_o,
  input  wire                         ready_i,
  output logic signed [csim_pkg::SimW-1:0] sim_o,
  output logic                        zero_o,
  output logic                        ovf_o
);

  localparam int unsigned RootW = csim_pkg::RootW;
  localparam int unsigned RemW  = csim_pkg::RemW;
  localparam int unsigned NumW  = csim_pkg::NumW;
  localparam int unsigned ProdW = csim_pkg::ProdW;
  localparam int unsigned QW    = csim_pkg::QW;
  localparam int unsigned SimW  = csim_pkg::SimW;
  localparam int unsigned StepW = csim_pkg::StepW;
  localparam int unsigned DotW  = csim_pkg::DotW;
  localparam int unsigned NormW = csim_pkg::NormW;
  localparam int unsigned SinW  = csim_pkg::SqrtInW;

  csim_pkg::back_state_e state_q, state_d;

  logic [StepW-1:0] step_q;
  logic             sqrt_end, div_end, out_free;
  logic             neg_q, zero_q, jovf_q;
  logic [DotW-1:0]  mag_q;
  logic [NormW-1:0] nb_q;
  logic [SinW-1:0]  x_q;
  logic [RootW-1:0] root_q, ra_q, root_n;
  logic [RemW-1:0]  rem_q, rem_n;
  logic [RemW+1:0]  rem_sh, trial, rem_sub;
  logic             sq_ge;
  logic [ProdW-1:0] d_q, r_q, r_n;
  logic [ProdW:0]   r_sh, r_sub;
  logic             dv_ge;
  logic [NumW-1:0]  num_q;
  logic [QW-1:0]    q_q, q_n;
  logic [QW:0]      q_sh, q_p1;
  logic [QW-1:0]    half;
  logic [SimW-1:0]  mag_sim, sim_n;
  logic [DotW-1:0]  jmag;

  // root digit step: two radicand bits per cycle
  always_comb begin
    rem_sh  = {rem_q, x_q[SinW-1 -: 2]};
    trial   = {2'b00, root_q, 2'b01};
    sq_ge   = rem_sh >= trial;
    rem_sub = rem_sh - trial;
    rem_n   = sq_ge ? rem_sub[RemW-1:0] : rem_sh[RemW-1:0];
    root_n  = {root_q[RootW-2:0], sq_ge};
  end

  // restoring division, quotient saturates as it grows
  always_comb begin
    r_sh  = {r_q, num_q[NumW-1]};
    r_sub = r_sh - {1'b0, d_q};
    dv_ge = r_sh >= {1'b0, d_q};
    r_n   = dv_ge ? r_sub[ProdW-1:0] : r_sh[ProdW-1:0];
    q_sh  = {q_q, dv_ge};
    q_n   = (q_sh > {1'b0, csim_pkg::Q_CAP}) ? csim_pkg::Q_CAP : q_sh[QW-1:0];
  end

  always_comb begin
    q_p1    = {1'b0, q_q} + 1'b1;
    half    = q_p1[QW:1];
    mag_sim = (half > {{(QW-SimW){1'b0}}, csim_pkg::SIM_ONE}) ? csim_pkg::SIM_ONE
                                                              : half[SimW-1:0];
    if (zero_q) begin
      sim_n = '0;
    end else begin
      sim_n = neg_q ? (~mag_sim + 1'b1) : mag_sim;
    end
    jmag = job_i.dot[DotW-1] ? (~job_i.dot + 1'b1) : job_i.dot;
  end

  assign sqrt_end = step_q == StepW'(RootW - 1);
  assign div_end  = step_q == StepW'(NumW - 1);
  assign out_free = !valid_o || ready_i;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      csim_pkg::B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = ((job_i.norm_a == '0) || (job_i.norm_b == '0)) ? csim_pkg::B_DONE
                                                                   : csim_pkg::B_SQRT_A;
        end
      end
      csim_pkg::B_SQRT_A: if (sqrt_end) state_d = csim_pkg::B_SQRT_B;
      csim_pkg::B_SQRT_B: if (sqrt_end) state_d = csim_pkg::B_MUL;
      csim_pkg::B_MUL:    state_d = csim_pkg::B_DIV;
      csim_pkg::B_DIV:    if (div_end) state_d = csim_pkg::B_DONE;
      csim_pkg::B_DONE:   if (out_free) state_d = csim_pkg::B_IDLE;
      default:            state_d = csim_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csim_pkg::B_IDLE;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == csim_pkg::B_DONE && out_free) begin
        valid_o <= 1'b1;
      end else if (ready_i) begin
        valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      csim_pkg::B_IDLE: begin
        neg_q  <= job_i.dot[DotW-1];
        mag_q  <= jmag;
        nb_q   <= job_i.norm_b;
        jovf_q <= job_i.ovf;
        zero_q <= (job_i.norm_a == '0) || (job_i.norm_b == '0);
        x_q    <= {1'b0, job_i.norm_a, {csim_pkg::FracShift{1'b0}}};
        root_q <= '0;
        rem_q  <= '0;
        step_q <= '0;
      end
      csim_pkg::B_SQRT_A: begin
        step_q <= sqrt_end ? '0 : step_q + 1'b1;
        if (sqrt_end) begin
          ra_q   <= root_n;
          x_q    <= {1'b0, nb_q, {csim_pkg::FracShift{1'b0}}};
          root_q <= '0;
          rem_q  <= '0;
        end else begin
          x_q    <= {x_q[SinW-3:0], 2'b00};
          root_q <= root_n;
          rem_q  <= rem_n;
        end
      end
      csim_pkg::B_SQRT_B: begin
        step_q <= sqrt_end ? '0 : step_q + 1'b1;
        x_q    <= {x_q[SinW-3:0], 2'b00};
        root_q <= root_n;
        rem_q  <= rem_n;
      end
      csim_pkg::B_MUL: begin
        d_q    <= ra_q * root_q;
        r_q    <= '0;
        q_q    <= '0;
        num_q  <= {mag_q, {csim_pkg::DivShift{1'b0}}};
        step_q <= '0;
      end
      csim_pkg::B_DIV: begin
        step_q <= step_q + 1'b1;
        r_q    <= r_n;
        q_q    <= q_n;
        num_q  <= {num_q[NumW-2:0], 1'b0};
      end
      csim_pkg::B_DONE: begin
        if (out_free) begin
          sim_o  <= sim_n;
          zero_o <= zero_q;
          ovf_o  <= jovf_q;
        end
      end
      default: ;
    endcase
  end

  a_zero_sim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && zero_o) |-> (sim_o == '0))
    else $error("zero norm with non-zero similarity");

  a_sim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((sim_o <= $signed(SimW'(16384))) && (sim_o >= -$signed(SimW'(16384)))))
    else $error("similarity outside plus or minus one");

endmodule
`default_nettype wire

// ----- rtl/cosine_similarity_engine_core.sv -----
// Cosine similarity of two vectors streamed as element pairs.
// Slave channel: one request per element pair, a and b in tdata (signed, ElemW
// bits each), tlast on the final pair. Pairs are taken one per cycle unless
// stalled; a MAC front end keeps the dot product and both norms (saturating).
// Master channel: one result per vector, similarity in tdata (signed Q1.14),
// tuser[0] zero norm, tuser[1] overflow (vector longer than MaxLen or an
// accumulator saturated).
// The result path runs through the shared 2-bit-per-cycle square root, once
// for each norm, then a multiply state and the restoring divider. Vectors
// with a zero norm skip the root and divide steps and go straight to the
// output state.
// A two-entry job queue sits between the MAC and the root/divide unit, so
// the next vector streams in while the previous one is being finished; the
// input stalls only when a tlast arrives with both queue entries taken.
// A stalled master holds its result register; the back end then waits in its
// done state and, once the queue fills, the input stalls too. Reset clears
// all accumulators, the queue and the output valid.
`default_nettype none
module cosine_similarity_engine_core #(
  parameter int unsigned MaxLen = csim_pkg::MaxLenDef,
  parameter int unsigned ElemW  = csim_pkg::ElemWDef
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // [ElemW-1:0] a_value, [2*ElemW-1:ElemW] b_value, zero fill above
  input  wire  [((2*ElemW+7)/8)*8-1:0]           s_axis_tdata_i,
  input  wire                                    s_axis_tlast_i,
  output logic                                   m_axis_tvalid_o,
  input  wire                                    m_axis_tready_i,
  // [15:0] similarity
  output logic [csim_pkg::SimW-1:0]              m_axis_tdata_o,
  // [0] zero_norm, [1] overflow
  output logic [1:0]                             m_axis_tuser_o
);

  csim_pkg::job_t push_job, pop_job;
  logic push, pop, full, empty, zero, ovf;
  logic signed [csim_pkg::SimW-1:0] sim;

  csim_front #(.MaxLen(MaxLen), .ElemW(ElemW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .a_i     ($signed(s_axis_tdata_i[ElemW-1:0])),
    .b_i     ($signed(s_axis_tdata_i[2*ElemW-1:ElemW])),
    .last_i  (s_axis_tlast_i),
    .push_o  (push),
    .job_o   (push_job),
    .full_i  (full)
  );

  csim_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (pop_job),
    .empty_o (empty)
  );

  csim_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (pop_job),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .sim_o   (sim),
    .zero_o  (zero),
    .ovf_o   (ovf)
  );

  assign m_axis_tdata_o = sim;
  assign m_axis_tuser_o = {ovf, zero};

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none
module testbench;

  localparam int unsigned MaxLen  = csim_pkg::MaxLenDef;
  localparam int unsigned ElemW   = csim_pkg::ElemWDef;
  localparam int unsigned DataW   = ((2*ElemW+7)/8)*8;
  localparam int unsigned Latency = 200;

  localparam logic signed [63:0] DOT_HI = (64'sd1 <<< 43) - 1;
  localparam logic signed [63:0] DOT_LO = -(64'sd1 <<< 43);
  localparam logic [63:0] NORM_TOP = (64'd1 << 43) - 1;
  localparam logic [63:0] QUOT_CAP = 64'd1 << 20;
  localparam logic [15:0] UNITY    = 16'd16384;

  typedef struct packed {
    logic signed [15:0] sim;
    logic               zero_norm;
    logic               overflow;
  } cos_res_t;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    bit                 last;
    bit                 typed;
    cos_res_t           res;
  } pair_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [DataW-1:0] s_axis_tdata_i = '0;
  logic s_axis_tlast_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;

  cosine_similarity_engine_core #(.MaxLen(MaxLen), .ElemW(ElemW)) DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tlast_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  // predictor state
  logic signed [63:0] dot_acc;
  logic [63:0] norm_a_acc, norm_b_acc;
  int unsigned pair_cnt;
  bit sat_seen;

  cos_res_t pending_cos[$];
  int errors = 0;
  int pairs_sent = 0;
  int vectors_sent = 0;
  int results_seen = 0;
  int long_vectors = 0;

  // sender pacing
  int burst_left = 0;
  bit no_gaps = 0;
  // receiver pacing: 0 never stall, 1 light, 2 heavy
  int stall_mode = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] norm_add(input logic [63:0] acc, input logic [63:0] p);
    if (p > NORM_TOP || acc > NORM_TOP - p) begin
      sat_seen = 1;
      return NORM_TOP;
    end
    return acc + p;
  endfunction

  function automatic cos_res_t cosine_of_sums();
    cos_res_t r;
    logic [63:0] ra, rb, d, mag, rem, q;
    logic [127:0] num;
    bit neg;
    r = '0;
    r.overflow = sat_seen;
    if (norm_a_acc == 0 || norm_b_acc == 0) begin
      r.zero_norm = 1'b1;
      return r;
    end
    ra = int_sqrt(norm_a_acc << 20);
    rb = int_sqrt(norm_b_acc << 20);
    d = ra * rb;
    neg = dot_acc < 0;
    mag = neg ? -dot_acc : dot_acc;
    num = {64'd0, mag} << 35;
    rem = 0;
    q = 0;
    for (int i = 127; i >= 0; i--) begin
      rem = (rem << 1) | num[i];
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q[0] = 1'b1;
      end
      if (q > QUOT_CAP) q = QUOT_CAP;
    end
    q = (q + 1) >> 1;
    if (q > UNITY) q = UNITY;
    r.sim = neg ? -q[15:0] : q[15:0];
    return r;
  endfunction

  // advance the model by one accepted pair; returns 1 when a result is due
  function automatic bit fold_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                                   input bit last, output cos_res_t res);
    logic signed [63:0] ae, be, s;
    ae = a;
    be = b;
    res = '0;
    if (pair_cnt >= MaxLen) begin
      sat_seen = 1;
    end else begin
      s = dot_acc + ae * be;
      if (s > DOT_HI) begin s = DOT_HI; sat_seen = 1; end
      if (s < DOT_LO) begin s = DOT_LO; sat_seen = 1; end
      dot_acc = s;
      norm_a_acc = norm_add(norm_a_acc, ae * ae);
      norm_b_acc = norm_add(norm_b_acc, be * be);
      pair_cnt++;
    end
    if (!last) return 0;
    res = cosine_of_sums();
    dot_acc = 0;
    norm_a_acc = 0;
    norm_b_acc = 0;
    pair_cnt = 0;
    sat_seen = 0;
    return 1;
  endfunction

  task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                           input bit last, input bit typed, input cos_res_t typed_res);
    cos_res_t res;
    int gap;
    if (!no_gaps && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = {a, b} == 0 ? '0 : DataW'({b, a});
    s_axis_tlast_i = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pairs_sent++;
    if (fold_pair(a, b, last, res)) begin
      vectors_sent++;
      pending_cos.push_back(typed ? typed_res : res);
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    s_axis_tlast_i = 1'b0;
  endtask

  task automatic send_vector(input int len, input int kind);
    logic signed [15:0] a, b;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: begin
          a = 16'($urandom);
          b = 16'($urandom);
        end
        1: begin
          a = 16'($urandom);
          b = a;
        end
        2: begin
          a = 16'($urandom);
          b = -a;
        end
        3: begin
          a = 16'($urandom_range(0, 64) - 32);
          b = 16'($urandom_range(0, 64) - 32);
        end
        default: begin
          a = ($urandom_range(0, 3) == 0) ? 16'sd0 : 16'($urandom);
          b = 16'sd0;
        end
      endcase
      send_pair(a, b, i == len - 1, 0, '0);
    end
  endtask

  task automatic drain_results();
    while (pending_cos.size() != 0) @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);
  endtask

  // receiver stall pattern
  initial begin
    forever begin
      @(negedge clk_i);
      case (stall_mode)
        0: m_axis_tready_i = 1'b1;
        1: m_axis_tready_i = $urandom_range(0, 3) != 0;
        default: m_axis_tready_i = $urandom_range(0, 3) == 0;
      endcase
    end
  end

  // result checker
  initial begin
    cos_res_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        results_seen++;
        if (pending_cos.size() == 0) begin
          errors++;
          $display("%0t: unexpected result sim=%0d user=%b", $time,
                   $signed(m_axis_tdata_o), m_axis_tuser_o);
        end else begin
          want = pending_cos.pop_front();
          if (m_axis_tdata_o !== want.sim) begin
            errors++;
            $display("%0t: similarity expected %0d actual %0d", $time, want.sim,
                     $signed(m_axis_tdata_o));
          end
          if (m_axis_tuser_o[0] !== want.zero_norm) begin
            errors++;
            $display("%0t: zero_norm expected %b actual %b", $time, want.zero_norm,
                     m_axis_tuser_o[0]);
          end
          if (m_axis_tuser_o[1] !== want.overflow) begin
            errors++;
            $display("%0t: overflow expected %b actual %b", $time, want.overflow,
                     m_axis_tuser_o[1]);
          end
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("cosine_similarity_engine_core test failed");
    $finish;
  end

  pair_row_t dir_rows[] = '{
    // single pair, parallel: exactly one
    '{16'sd2048, 16'sd2048, 1, 1, '{16'sd16384, 1'b0, 1'b0}},
    // extremes, antiparallel and parallel
    '{-16'sd32768, 16'sd32767, 1, 1, '{-16'sd16384, 1'b0, 1'b0}},
    '{16'sd32767, 16'sd32767, 1, 1, '{16'sd16384, 1'b0, 1'b0}},
    '{-16'sd32768, -16'sd32768, 1, 1, '{16'sd16384, 1'b0, 1'b0}},
    // zero norm on either side and both
    '{16'sd0, 16'sd1234, 1, 1, '{16'sd0, 1'b1, 1'b0}},
    '{-16'sd5, 16'sd0, 1, 1, '{16'sd0, 1'b1, 1'b0}},
    '{16'sd0, 16'sd0, 1, 1, '{16'sd0, 1'b1, 1'b0}},
    // orthogonal pair of two-element vectors
    '{16'sd1000, 16'sd0, 0, 0, '0},
    '{16'sd0, 16'sd1000, 1, 1, '{16'sd0, 1'b0, 1'b0}},
    // general multi-element vectors, predicted, and one typed antiparallel single pair
    '{16'sd300, -16'sd700, 0, 0, '0},
    '{-16'sd32768, 16'sd1, 0, 0, '0},
    '{16'sd32767, -16'sd32768, 0, 0, '0},
    '{16'sd12, 16'sd13, 1, 0, '0},
    '{16'sd1, 16'sd1, 0, 0, '0},
    '{16'sd1, -16'sd1, 0, 0, '0},
    '{16'sd1, 16'sd2, 1, 0, '0},
    '{-16'sd1, 16'sd1, 1, 1, '{-16'sd16384, 1'b0, 1'b0}},
    '{16'sd21845, -16'sd10922, 0, 0, '0},
    '{-16'sd21846, 16'sd10921, 1, 0, '0}
  };

  initial begin
    int len, kind;
    dot_acc = 0;
    norm_a_acc = 0;
    norm_b_acc = 0;
    pair_cnt = 0;
    sat_seen = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    stall_mode = 1;
    foreach (dir_rows[i])
      send_pair(dir_rows[i].a, dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed,
                dir_rows[i].res);

    // hold off until the pipe is empty
    drain_results();

    // full-length vector and two too-long ones
    no_gaps = 1;
    stall_mode = 0;
    foreach (dir_rows[i]) if (i < 3) begin
      long_vectors++;
      send_vector(MaxLen + i * 3, $urandom_range(0, 2));
    end
    no_gaps = 0;

    while (pairs_sent < MaxLen * 3 + 820) begin
      if ($urandom_range(0, 40) == 0) begin
        stall_mode = $urandom_range(0, 2);
        no_gaps = $urandom_range(0, 3) == 0;
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      kind = $urandom_range(0, 9);
      send_vector(len, kind < 5 ? 0 : kind - 4);
    end

    drain_results();
    $display("%0d pairs in %0d vectors (%0d of full or excess length), %0d results checked",
             pairs_sent, vectors_sent, long_vectors, results_seen);
    if (errors == 0) begin
      $display("cosine_similarity_engine_core test passed");
    end else begin
      $display("cosine_similarity_engine_core test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
